/* hdl/pal_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list package
// Shared types, codes and sizes for the positional array list engine.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int STORE_AW   = 6;   // address width of the entry store
    localparam int COUNT_W    = 7;   // width of the entry count
    localparam int CMDQ_DEPTH = 2;   // command queue between front and back
    localparam int OUTQ_DEPTH = 4;   // result queue at the output
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_LW    = 3;
    // Traverse reads are only issued while queued plus in-flight results
    // stay at or below this mark, so the result queue never overflows.
    localparam logic [3:0] TRAV_CREDIT = 4'd2;

    typedef enum logic [1:0] {
        OP_TRAVERSE = 2'd0,
        OP_INSERT   = 2'd1,
        OP_DELETE   = 2'd2,
        OP_SEARCH   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_INSERT_FAIL = 3'd1,
        ST_DELETE_BAD  = 3'd2,
        ST_NOT_FOUND   = 3'd3,
        ST_EMPTY       = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_INS_MOVE,
        BS_DEL_MOVE,
        BS_SEARCH,
        BS_TRAV,
        BS_REPLY
    } t_back_state;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
        logic [6:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] item_value;
        logic [5:0]         item_index;
        logic [6:0]         entry_count;
        logic               last;
    } t_out_item;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] value;
        logic [6:0]         position;
    } t_cmd;

    typedef struct packed {
        logic                wr_en;
        logic [STORE_AW-1:0] wr_addr;
        logic [31:0]         wr_data;
        logic                rd_en;
        logic [STORE_AW-1:0] rd_addr;
    } t_ram_req;

endpackage

/* hdl/positional_array_list_engine.sv */
`timescale 1ns / 1ps
// Throughput: one operation at a time; traverse then pushes one result a cycle
//   while the result queue leaves it credit, as the single read port of the
//   entry store sets every loop at one entry.
// Reset clears the count, both queues and the control state, not the entry store.
// ----------------------------------------------------------------------------
// Positional array list engine
// Ordered list of signed 32-bit entries with insert, delete, search and
// traverse operations, reported through status codes.
// ----------------------------------------------------------------------------
module positional_array_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pal_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pal_pkg::t_out_item o_out_item
);

    // Address width of the physical store follows the capacity.
    localparam int RamAw = $clog2(CAPACITY);

    // The front end takes each input transaction into a two-entry command
    // queue, so new commands are accepted while the back end is busy.
    logic                        w_cmd_vld;
    pal_pkg::t_cmd               w_cmd;
    logic                        w_cmd_pop;

    // The back end drives the store and pushes results into the result queue.
    pal_pkg::t_ram_req           w_ram;
    logic [31:0]                 w_rd_data;
    logic                        w_res_push;
    pal_pkg::t_out_item          w_res_item;
    logic [pal_pkg::OUTQ_LW-1:0] w_q_level;
    logic                        w_q_full;

    pal_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_cmd_vld  (w_cmd_vld),
        .o_cmd      (w_cmd),
        .i_cmd_pop  (w_cmd_pop)
    );

    pal_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (w_cmd_vld),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .o_ram      (w_ram),
        .i_rd_data  (w_rd_data),
        .o_res_push (w_res_push),
        .o_res_item (w_res_item),
        .i_q_level  (w_q_level),
        .i_q_full   (w_q_full)
    );

    // Entry store. Only entries below the count are ever read, and those have
    // always been written, so the store needs no reset value.
    pal_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY),
        .AW    (RamAw)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram.wr_en),
        .i_wr_addr (w_ram.wr_addr[RamAw-1:0]),
        .i_wr_data (w_ram.wr_data),
        .i_rd_en   (w_ram.rd_en),
        .i_rd_addr (w_ram.rd_addr[RamAw-1:0]),
        .o_rd_data (w_rd_data)
    );

    // The result queue decouples the output stall from the traverse loop.
    pal_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res_push),
        .i_item      (w_res_item),
        .o_level     (w_q_level),
        .o_full      (w_q_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    // The traverse credit and the reply wait must keep the result queue from
    // overflowing.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> (w_q_level < pal_pkg::OUTQ_LW'(pal_pkg::OUTQ_DEPTH)))
        else $error("result queue overflow");

    // A command is only taken from the queue when one is there.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_vld)
        else $error("command popped from empty queue");

    // Only a traverse gives more than one result, and all of those are ok.
    a_mid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.last) |-> (o_out_item.status == pal_pkg::ST_OK))
        else $error("non-final result with failure status");

    // The reported count never exceeds the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.entry_count <= 7'(CAPACITY)))
        else $error("entry count above capacity");
`endif

endmodule

/* hdl/pal_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/pal_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accepts input transactions, decodes the operation and queues commands.
// ----------------------------------------------------------------------------
module pal_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pal_pkg::t_in_item i_in_item,
    output logic              o_cmd_vld,
    output pal_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);

    pal_pkg::t_cmd r_q [pal_pkg::CMDQ_DEPTH];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_level;
    logic [1:0]    n_level;
    logic          w_push;
    pal_pkg::t_cmd w_cmd;

    always_comb begin
        w_cmd.value    = i_in_item.value;
        w_cmd.position = i_in_item.position;
        unique case (i_in_item.operation)
            pal_pkg::OP_TRAVERSE: w_cmd.op = pal_pkg::OP_TRAVERSE;
            pal_pkg::OP_INSERT:   w_cmd.op = pal_pkg::OP_INSERT;
            pal_pkg::OP_DELETE:   w_cmd.op = pal_pkg::OP_DELETE;
            pal_pkg::OP_SEARCH:   w_cmd.op = pal_pkg::OP_SEARCH;
            default:              w_cmd.op = pal_pkg::OP_TRAVERSE;
        endcase
    end

    assign o_in_stall = (r_level == 2'(pal_pkg::CMDQ_DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_cmd_vld  = (r_level != 2'd0);
    assign o_cmd      = r_q[r_rd_ptr];

    always_comb begin
        n_level = r_level;
        if (w_push && !i_cmd_pop) begin
            n_level = r_level + 2'd1;
        end else if (!w_push && i_cmd_pop) begin
            n_level = r_level - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

/* hdl/pal_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Small FIFO that holds finished results until the output side takes them.
// ----------------------------------------------------------------------------
module pal_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  pal_pkg::t_out_item          i_item,
    output logic [pal_pkg::OUTQ_LW-1:0] o_level,
    output logic                        o_full,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output pal_pkg::t_out_item          o_out_item
);

    pal_pkg::t_out_item          r_mem [pal_pkg::OUTQ_DEPTH];
    logic [pal_pkg::OUTQ_AW-1:0] r_wr_ptr;
    logic [pal_pkg::OUTQ_AW-1:0] r_rd_ptr;
    logic [pal_pkg::OUTQ_LW-1:0] r_level;
    logic [pal_pkg::OUTQ_LW-1:0] n_level;
    logic                        w_pop;

    assign o_level     = r_level;
    assign o_full      = (r_level == pal_pkg::OUTQ_LW'(pal_pkg::OUTQ_DEPTH));
    assign o_out_valid = (r_level != '0);
    assign o_out_item  = r_mem[r_rd_ptr];
    assign w_pop       = o_out_valid && !i_out_stall;

    always_comb begin
        n_level = r_level;
        if (i_push && !w_pop) begin
            n_level = r_level + pal_pkg::OUTQ_LW'(1);
        end else if (!i_push && w_pop) begin
            n_level = r_level - pal_pkg::OUTQ_LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + pal_pkg::OUTQ_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + pal_pkg::OUTQ_AW'(1);
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* hdl/pal_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Executes queued commands against the entry store, one at a time.
// ----------------------------------------------------------------------------
module pal_back #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_vld,
    input  pal_pkg::t_cmd               i_cmd,
    output logic                        o_cmd_pop,
    output pal_pkg::t_ram_req           o_ram,
    input  logic [31:0]                 i_rd_data,
    output logic                        o_res_push,
    output pal_pkg::t_out_item          o_res_item,
    input  logic [pal_pkg::OUTQ_LW-1:0] i_q_level,
    input  logic                        i_q_full
);

    localparam logic [6:0] CapCount = 7'(CAPACITY);

    pal_pkg::t_back_state r_state, n_state;
    logic [6:0]           r_count, n_count;
    logic signed [31:0]   r_val, n_val;
    logic [6:0]           r_pos, n_pos;
    logic [6:0]           r_ptr, n_ptr;
    logic                 r_rd_vld, n_rd_vld;
    logic [5:0]           r_rd_idx, n_rd_idx;
    pal_pkg::t_status     r_status, n_status;
    logic [5:0]           r_idx, n_idx;
    logic [6:0]           w_ptr_dec;
    logic                 w_credit;

    assign w_ptr_dec = r_ptr - 7'd1;
    assign w_credit  = ({1'b0, i_q_level} + {3'b000, r_rd_vld}) <= pal_pkg::TRAV_CREDIT;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_val      = r_val;
        n_pos      = r_pos;
        n_ptr      = r_ptr;
        n_rd_vld   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_status   = r_status;
        n_idx      = r_idx;
        o_cmd_pop  = 1'b0;
        o_ram      = '0;
        o_res_push = 1'b0;
        o_res_item = '0;

        unique case (r_state)
            pal_pkg::BS_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_pop = 1'b1;
                    n_val     = i_cmd.value;
                    n_pos     = i_cmd.position;
                    n_idx     = '0;
                    unique case (i_cmd.op)
                        pal_pkg::OP_INSERT: begin
                            if (r_count >= CapCount || i_cmd.position > r_count) begin
                                n_status = pal_pkg::ST_INSERT_FAIL;
                                n_state  = pal_pkg::BS_REPLY;
                            end else begin
                                n_ptr   = r_count;
                                n_state = pal_pkg::BS_INS_MOVE;
                            end
                        end
                        pal_pkg::OP_DELETE: begin
                            if (i_cmd.position >= r_count) begin
                                n_status = pal_pkg::ST_DELETE_BAD;
                                n_state  = pal_pkg::BS_REPLY;
                            end else begin
                                n_ptr   = i_cmd.position + 7'd1;
                                n_state = pal_pkg::BS_DEL_MOVE;
                            end
                        end
                        pal_pkg::OP_SEARCH: begin
                            n_ptr   = '0;
                            n_state = pal_pkg::BS_SEARCH;
                        end
                        pal_pkg::OP_TRAVERSE: begin
                            if (r_count == 7'd0) begin
                                n_status = pal_pkg::ST_EMPTY;
                                n_state  = pal_pkg::BS_REPLY;
                            end else begin
                                n_ptr   = '0;
                                n_state = pal_pkg::BS_TRAV;
                            end
                        end
                        default: n_state = pal_pkg::BS_IDLE;
                    endcase
                end
            end

            pal_pkg::BS_INS_MOVE: begin
                // Move entries up one, from the top of the list down to the position.
                if (r_rd_vld) begin
                    o_ram.wr_en   = 1'b1;
                    o_ram.wr_addr = r_rd_idx + 6'd1;
                    o_ram.wr_data = i_rd_data;
                end
                if (r_ptr > r_pos) begin
                    o_ram.rd_en   = 1'b1;
                    o_ram.rd_addr = w_ptr_dec[5:0];
                    n_rd_vld      = 1'b1;
                    n_rd_idx      = w_ptr_dec[5:0];
                    n_ptr         = w_ptr_dec;
                end else if (!r_rd_vld) begin
                    o_ram.wr_en   = 1'b1;
                    o_ram.wr_addr = r_pos[5:0];
                    o_ram.wr_data = r_val;
                    n_count       = r_count + 7'd1;
                    n_status      = pal_pkg::ST_OK;
                    n_state       = pal_pkg::BS_REPLY;
                end
            end

            pal_pkg::BS_DEL_MOVE: begin
                // Move entries down one, from above the position to the top.
                if (r_rd_vld) begin
                    o_ram.wr_en   = 1'b1;
                    o_ram.wr_addr = r_rd_idx - 6'd1;
                    o_ram.wr_data = i_rd_data;
                end
                if (r_ptr < r_count) begin
                    o_ram.rd_en   = 1'b1;
                    o_ram.rd_addr = r_ptr[5:0];
                    n_rd_vld      = 1'b1;
                    n_rd_idx      = r_ptr[5:0];
                    n_ptr         = r_ptr + 7'd1;
                end else if (!r_rd_vld) begin
                    n_count  = r_count - 7'd1;
                    n_status = pal_pkg::ST_OK;
                    n_state  = pal_pkg::BS_REPLY;
                end
            end

            pal_pkg::BS_SEARCH: begin
                if (r_rd_vld && i_rd_data == r_val) begin
                    n_idx    = r_rd_idx;
                    n_status = pal_pkg::ST_OK;
                    n_state  = pal_pkg::BS_REPLY;
                end else if (r_ptr < r_count) begin
                    o_ram.rd_en   = 1'b1;
                    o_ram.rd_addr = r_ptr[5:0];
                    n_rd_vld      = 1'b1;
                    n_rd_idx      = r_ptr[5:0];
                    n_ptr         = r_ptr + 7'd1;
                end else if (!r_rd_vld) begin
                    n_status = pal_pkg::ST_NOT_FOUND;
                    n_state  = pal_pkg::BS_REPLY;
                end
            end

            pal_pkg::BS_TRAV: begin
                if (r_rd_vld) begin
                    o_res_push             = 1'b1;
                    o_res_item.status      = pal_pkg::ST_OK;
                    o_res_item.item_value  = i_rd_data;
                    o_res_item.item_index  = r_rd_idx;
                    o_res_item.entry_count = r_count;
                    o_res_item.last        = ({1'b0, r_rd_idx} + 7'd1) == r_count;
                end
                if (r_ptr < r_count) begin
                    if (w_credit) begin
                        o_ram.rd_en   = 1'b1;
                        o_ram.rd_addr = r_ptr[5:0];
                        n_rd_vld      = 1'b1;
                        n_rd_idx      = r_ptr[5:0];
                        n_ptr         = r_ptr + 7'd1;
                    end
                end else if (!r_rd_vld) begin
                    n_state = pal_pkg::BS_IDLE;
                end
            end

            pal_pkg::BS_REPLY: begin
                if (!i_q_full) begin
                    o_res_push             = 1'b1;
                    o_res_item.status      = r_status;
                    o_res_item.item_index  = r_idx;
                    o_res_item.entry_count = r_count;
                    o_res_item.last        = 1'b1;
                    n_state                = pal_pkg::BS_IDLE;
                end
            end

            default: n_state = pal_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pal_pkg::BS_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_ptr    <= n_ptr;
        r_rd_idx <= n_rd_idx;
        r_status <= n_status;
        r_idx    <= n_idx;
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list engine testbench
// Drives insert, delete, search and traverse transactions into the engine,
// predicts every result from a shadow copy of the list, and compares each
// result field by field while both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD    = 10;
    localparam int CAPACITY      = 64;
    // The run is declared hung when this many cycles pass with work pending
    // and no transaction on either side.
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 300;
    // Longest single operations walk the whole list, as a search with no match in a full list does.
    localparam int SETTLE_CYCLES = 100;
    localparam int MAX_REPORTS   = 10;

    localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic [6:0]         POS_TOP   = 7'd127;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input has a known value from
    // time zero; reset starts low and is released on a falling edge.
    // ------------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    pal_pkg::t_in_item  i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    pal_pkg::t_out_item o_out_item;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    positional_array_list_engine #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    // ------------------------------------------------------------------------
    // Prediction. The shadow list mirrors the entries the engine should hold.
    // It is updated at the edge where an input transaction is accepted, and
    // the results that transaction must produce are queued in order.
    // ------------------------------------------------------------------------
    logic signed [31:0] shadow_list[$];
    pal_pkg::t_out_item pending_results[$];
    int unsigned        mismatch_count = 0;

    function automatic void queue_result(pal_pkg::t_status st, logic signed [31:0] val,
                                         int idx, logic last_flag);
        pal_pkg::t_out_item r;
        r.status      = st;
        r.item_value  = val;
        r.item_index  = 6'(idx);
        r.entry_count = 7'(shadow_list.size());
        r.last        = last_flag;
        pending_results.push_back(r);
    endfunction

    function automatic void apply_list_operation(pal_pkg::t_in_item item);
        int pos;
        int found;
        pos   = int'(item.position);
        found = -1;
        case (pal_pkg::t_op'(item.operation))
            pal_pkg::OP_INSERT: begin
                // A full list or a position past the count leaves the list alone.
                // A position equal to the count appends.
                if (shadow_list.size() >= CAPACITY || pos > shadow_list.size()) begin
                    queue_result(pal_pkg::ST_INSERT_FAIL, '0, 0, 1'b1);
                end else begin
                    shadow_list.insert(pos, item.value);
                    queue_result(pal_pkg::ST_OK, '0, 0, 1'b1);
                end
            end
            pal_pkg::OP_DELETE: begin
                if (pos >= shadow_list.size()) begin
                    queue_result(pal_pkg::ST_DELETE_BAD, '0, 0, 1'b1);
                end else begin
                    shadow_list.delete(pos);
                    queue_result(pal_pkg::ST_OK, '0, 0, 1'b1);
                end
            end
            pal_pkg::OP_SEARCH: begin
                // Only the first matching entry counts.
                foreach (shadow_list[i]) begin
                    if (found < 0 && shadow_list[i] == item.value) begin
                        found = i;
                    end
                end
                if (found < 0) begin
                    queue_result(pal_pkg::ST_NOT_FOUND, '0, 0, 1'b1);
                end else begin
                    queue_result(pal_pkg::ST_OK, '0, found, 1'b1);
                end
            end
            default: begin
                // Traverse: one result per entry, or a single empty marker.
                if (shadow_list.size() == 0) begin
                    queue_result(pal_pkg::ST_EMPTY, '0, 0, 1'b1);
                end else begin
                    foreach (shadow_list[i]) begin
                        queue_result(pal_pkg::ST_OK, shadow_list[i], i,
                                     i == shadow_list.size() - 1);
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking. Each accepted output transaction is compared against
    // the oldest pending expectation. Only the first few failures are printed.
    // ------------------------------------------------------------------------
    function automatic void report_failure(string what, pal_pkg::t_out_item want,
                                           pal_pkg::t_out_item got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%s: expected status=%0d value=%0d index=%0d count=%0d last=%0d, got status=%0d value=%0d index=%0d count=%0d last=%0d",
                     what, want.status, want.item_value, want.item_index,
                     want.entry_count, want.last, got.status, got.item_value,
                     got.item_index, got.entry_count, got.last);
        end
    endfunction

    always @(posedge i_clk) begin
        pal_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_failure("unexpected result", '0, o_out_item);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.status !== want.status
                        || o_out_item.item_value !== want.item_value
                        || o_out_item.item_index !== want.item_index
                        || o_out_item.entry_count !== want.entry_count
                        || o_out_item.last !== want.last) begin
                    report_failure("result mismatch", want, o_out_item);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It stalls in short random runs at a rate the current test
    // sets, and a test can ask for one long hold-off, which is counted down
    // here cycle by cycle.
    // ------------------------------------------------------------------------
    int unsigned stall_pct    = 0;
    int unsigned hold_request = 0;
    int unsigned stall_run    = 0;

    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            stall_run    = hold_request;
            hold_request = 0;
        end else if (stall_run == 0 && stall_pct != 0
                     && $urandom_range(0, 99) < stall_pct) begin
            stall_run = $urandom_range(1, 4);
        end
        i_out_stall = (stall_run != 0);
        if (stall_run != 0) begin
            stall_run--;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. Counts cycles in which work is pending but no transaction
    // moves on either side.
    // ------------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else if (pending_results.size() != 0 || i_in_valid) begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Transactions go out in bursts of random length separated by
    // random gaps; a gap limit of zero means back-to-back offers. Valid stays
    // high from one accepted transaction to the next within a burst, so any
    // task that lets time pass between sends must drop it first.
    // ------------------------------------------------------------------------
    int unsigned gap_max    = 0;
    int unsigned burst_left = 0;

    task automatic send_operation(pal_pkg::t_op op, logic signed [31:0] val,
                                  logic [6:0] pos);
        pal_pkg::t_in_item item;
        item.operation = op;
        item.value     = val;
        item.position  = pos;
        @(negedge i_clk);
        if (gap_max != 0) begin
            if (burst_left == 0) begin
                i_in_valid = 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
                burst_left = $urandom_range(1, 8);
            end
            burst_left--;
        end
        i_in_item  = item;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        apply_list_operation(item);
    endtask

    // Drops valid and waits until every predicted result has been checked.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Returns an entry already in the list with the given chance in percent,
    // otherwise a fully random 32-bit value.
    function automatic logic signed [31:0] pick_value(int unsigned hit_pct);
        if (shadow_list.size() != 0 && $urandom_range(0, 99) < hit_pct) begin
            return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        end
        return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Every operation against an empty list, including the top position.
    task automatic test_empty_list();
        gap_max   = 0;
        stall_pct = 0;
        send_operation(pal_pkg::OP_TRAVERSE, '0, '0);          // single empty marker
        send_operation(pal_pkg::OP_SEARCH, '0, '0);            // not found
        send_operation(pal_pkg::OP_DELETE, '0, '0);            // nothing to delete
        send_operation(pal_pkg::OP_DELETE, '1, POS_TOP);
        send_operation(pal_pkg::OP_INSERT, VALUE_MAX, 7'd1);   // past the count
        send_operation(pal_pkg::OP_INSERT, VALUE_MIN, POS_TOP);
        wait_for_results();
    endtask

    // Inserts at head, middle and tail with extreme values, duplicate search,
    // deletes at head, middle, tail and at the count, down to empty again.
    task automatic test_directed_edits();
        gap_max   = 2;
        stall_pct = 30;
        send_operation(pal_pkg::OP_INSERT, VALUE_MAX, 7'd0);   // MAX
        send_operation(pal_pkg::OP_INSERT, VALUE_MIN, 7'd1);   // MAX MIN (append)
        send_operation(pal_pkg::OP_INSERT, -32'sd1, 7'd1);     // MAX -1 MIN
        send_operation(pal_pkg::OP_INSERT, 32'sd0, 7'd0);      // 0 MAX -1 MIN
        send_operation(pal_pkg::OP_INSERT, VALUE_MAX, 7'd2);   // 0 MAX MAX -1 MIN
        send_operation(pal_pkg::OP_INSERT, 32'sd5, 7'd6);      // fails, past the count
        send_operation(pal_pkg::OP_SEARCH, VALUE_MAX, POS_TOP); // first of two matches
        send_operation(pal_pkg::OP_SEARCH, VALUE_MIN, '0);
        send_operation(pal_pkg::OP_SEARCH, 32'sd12345, '0);    // not found
        send_operation(pal_pkg::OP_TRAVERSE, '1, POS_TOP);
        send_operation(pal_pkg::OP_DELETE, '0, 7'd5);          // at the count, fails
        send_operation(pal_pkg::OP_DELETE, '0, 7'd4);          // tail
        send_operation(pal_pkg::OP_DELETE, '0, 7'd0);          // head
        send_operation(pal_pkg::OP_DELETE, '0, 7'd1);          // middle
        send_operation(pal_pkg::OP_TRAVERSE, '0, '0);
        send_operation(pal_pkg::OP_SEARCH, -32'sd1, '0);
        send_operation(pal_pkg::OP_DELETE, '0, 7'd0);
        send_operation(pal_pkg::OP_DELETE, '0, 7'd0);          // list empty again
        send_operation(pal_pkg::OP_TRAVERSE, '0, '0);
        wait_for_results();
    endtask

    // Fills the list to capacity with random values at random legal
    // positions, then exercises the full-list cases and a full traverse.
    task automatic test_full_list();
        gap_max   = 4;
        stall_pct = 25;
        while (shadow_list.size() < CAPACITY) begin
            send_operation(pal_pkg::OP_INSERT, pick_value(20),
                           7'($urandom_range(0, shadow_list.size())));
        end
        send_operation(pal_pkg::OP_INSERT, pick_value(0), 7'(CAPACITY));  // full, at the count
        send_operation(pal_pkg::OP_INSERT, pick_value(0), 7'd0);          // full, at the head
        send_operation(pal_pkg::OP_SEARCH, pick_value(100), '0);
        send_operation(pal_pkg::OP_TRAVERSE, '0, '0);
        send_operation(pal_pkg::OP_DELETE, '0, 7'(CAPACITY));             // at the count, fails
        send_operation(pal_pkg::OP_DELETE, '0, 7'(CAPACITY - 1));
        send_operation(pal_pkg::OP_DELETE, '0, 7'd0);
        wait_for_results();
    endtask

    // Random operations, mostly well formed. The insert share steers the list
    // toward full or toward empty; the idling arguments set both sides.
    task automatic test_random_mix(int unsigned count, int unsigned insert_share,
                                   int unsigned gap_limit, int unsigned stall_rate);
        int unsigned pick;
        logic [6:0]  pos;
        gap_max   = gap_limit;
        stall_pct = stall_rate;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            pos  = 7'($urandom_range(0, 127));
            if (pick < 8) begin
                send_operation(pal_pkg::OP_TRAVERSE, $urandom, pos);
            end else if (pick < 28) begin
                send_operation(pal_pkg::OP_SEARCH, pick_value(70), pos);
            end else if (pick < 28 + insert_share) begin
                if ($urandom_range(0, 99) < 85) begin
                    pos = 7'($urandom_range(0, shadow_list.size()));
                end
                send_operation(pal_pkg::OP_INSERT, pick_value(20), pos);
            end else begin
                if (shadow_list.size() != 0 && $urandom_range(0, 99) < 85) begin
                    pos = 7'($urandom_range(0, shadow_list.size() - 1));
                end
                send_operation(pal_pkg::OP_DELETE, $urandom, pos);
            end
        end
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering back to back, so the result queue fills and the engine stalls
    // its input. Three traverses make sure there is plenty to back up.
    task automatic test_backpressure();
        gap_max      = 0;
        stall_pct    = 0;
        hold_request = HOLD_CYCLES;
        send_operation(pal_pkg::OP_TRAVERSE, '0, '0);
        send_operation(pal_pkg::OP_INSERT, pick_value(0), 7'd0);
        send_operation(pal_pkg::OP_SEARCH, pick_value(100), '0);
        send_operation(pal_pkg::OP_TRAVERSE, '0, '0);
        send_operation(pal_pkg::OP_DELETE, '0, 7'd0);
        send_operation(pal_pkg::OP_SEARCH, pick_value(50), '0);
        send_operation(pal_pkg::OP_INSERT, pick_value(0), 7'(shadow_list.size()));
        send_operation(pal_pkg::OP_TRAVERSE, '0, '0);
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence. Each test ends with the sender paused until every expected
    // result has arrived.
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_directed_edits();
        test_full_list();
        test_random_mix(12, 20, 6, 40);   // shrinking, heavy idling
        test_random_mix(10, 50, 0, 0);    // growing, no idling at all
        test_backpressure();
        test_random_mix(10, 35, 3, 15);

        wait_for_results();
        // Give a misbehaving engine time to emit anything extra.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
